// ===== rtl/core/nps_pkg.sv =====
package nps_pkg;

   localparam int DEFAULT_MAX_POINTS = 4096;
   localparam int DEFAULT_COORD_BITS = 24;

   localparam int SLOT_W  = 12;
   localparam int COUNT_W = 13;
   localparam int DIST_W  = 50;

   localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic write_point;
      logic start_query;
      logic issue_read;
      logic load_result;
   } ctrl_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic scan_last;
      logic pipe_busy;
   } ctrl_status_type;

endpackage

// ===== rtl/core/nps_req_if.sv =====
interface nps_req_if #(
   parameter int COORD_BITS = nps_pkg::DEFAULT_COORD_BITS
);
   import nps_pkg::*;

   logic                         valid;
   logic                         ready;
   logic                         operation;
   logic [SLOT_W-1:0]            slot;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;

   modport source (
      output valid, operation, slot, coord_x, coord_y, coord_z,
      input  ready
   );

   modport sink (
      input  valid, operation, slot, coord_x, coord_y, coord_z,
      output ready
   );

endinterface

// ===== rtl/core/nps_rsp_if.sv =====
interface nps_rsp_if;
   import nps_pkg::*;

   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] nearest_slot;
   logic [DIST_W-1:0] best_distance_sq;
   logic              table_empty;

   modport source (
      output valid, nearest_slot, best_distance_sq, table_empty,
      input  ready
   );

   modport sink (
      input  valid, nearest_slot, best_distance_sq, table_empty,
      output ready
   );

endinterface

// ===== rtl/core/nps_ram.sv =====
module nps_ram #(
   parameter int WIDTH = 72,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/nps_ctrl.sv =====
module nps_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_operation,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  nps_pkg::ctrl_status_type status,
   output nps_pkg::ctrl_cmd_type    cmd
);
   import nps_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.write_point = accept && (req_operation == OP_LOAD);
      cmd.start_query = accept && (req_operation == OP_QUERY);
      cmd.issue_read  = (state_ff == ST_SCAN);
      cmd.load_result = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start_query) begin
               state_in = status.count_zero ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (cmd.load_result) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/nps_datapath.sv =====
module nps_datapath #(
   parameter int MAX_POINTS = nps_pkg::DEFAULT_MAX_POINTS,
   parameter int COORD_BITS = nps_pkg::DEFAULT_COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [nps_pkg::COUNT_W-1:0]   csr_write_data,
   input  logic [nps_pkg::SLOT_W-1:0]    slot,
   input  logic signed [COORD_BITS-1:0]  coord_x,
   input  logic signed [COORD_BITS-1:0]  coord_y,
   input  logic signed [COORD_BITS-1:0]  coord_z,
   input  nps_pkg::ctrl_cmd_type         cmd,
   output nps_pkg::ctrl_status_type      status,
   output logic [nps_pkg::SLOT_W-1:0]    nearest_slot,
   output logic [nps_pkg::DIST_W-1:0]    best_distance_sq,
   output logic                          table_empty
);
   import nps_pkg::*;

   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int WIDE_W = (ADDR_W + 1 > COUNT_W) ? ADDR_W + 1 : COUNT_W;
   localparam int MAG_W  = COORD_BITS + 1;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 2;
   localparam int CMP_W  = (SUM_W > DIST_W + 1) ? SUM_W : DIST_W + 1;
   localparam int PT_W   = 3 * COORD_BITS;
   localparam logic [WIDE_W-1:0] MAX_WIDE = WIDE_W'(MAX_POINTS);

   function automatic logic [MAG_W-1:0] abs_diff(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b
   );
      logic signed [MAG_W-1:0] d;
      d = MAG_W'(a) - MAG_W'(b);
      return d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
   endfunction

   logic [COUNT_W-1:0] point_count_ff;

   logic [WIDE_W-1:0]  count_wide, count_sat, last_wide, slot_wide;
   logic               slot_ok;
   logic [ADDR_W-1:0]  last_ff, last_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;

   logic signed [COORD_BITS-1:0] qx_ff, qy_ff, qz_ff;

   logic [PT_W-1:0]    rd_data;
   logic signed [COORD_BITS-1:0] px, py, pz;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic [ADDR_W-1:0]  i1_ff, i2_ff, i3_ff, i4_ff;
   logic [MAG_W-1:0]   adx_ff, ady_ff, adz_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff, sqz_ff;
   logic [SQ_W-1:0]    sqx_in, sqy_in, sqz_in;
   logic [CMP_W-1:0]   sum_c;
   logic [DIST_W-1:0]  dist4_ff, dist4_in;

   logic               first_ff;
   logic               better;
   logic [ADDR_W-1:0]  best_idx_ff;
   logic [DIST_W-1:0]  best_dist_ff;
   logic               empty_ff;

   logic [SLOT_W-1:0]  out_slot_ff;
   logic [DIST_W-1:0]  out_dist_ff;
   logic               out_empty_ff;
   logic [WIDE_W-1:0]  best_idx_wide;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= '0;
      end else if (csr_write_enable) begin
         point_count_ff <= csr_write_data;
      end
   end

   always_comb begin
      count_wide = WIDE_W'(point_count_ff);
      count_sat  = (count_wide > MAX_WIDE) ? MAX_WIDE : count_wide;
      last_wide  = count_sat - WIDE_W'(1);
      last_in    = last_wide[ADDR_W-1:0];
      slot_wide  = WIDE_W'(slot);
      slot_ok    = (slot_wide < MAX_WIDE);
      idx_in     = idx_ff + ADDR_W'(1);
   end

   always_comb begin
      status.count_zero = (point_count_ff == '0);
      status.scan_last  = (idx_ff == last_ff);
      status.pipe_busy  = v1_ff || v2_ff || v3_ff || v4_ff;
   end

   nps_ram #(
      .WIDTH (PT_W),
      .DEPTH (MAX_POINTS)
   ) u_point_ram (
      .clock   (clock),
      .wr_en   (cmd.write_point && slot_ok),
      .wr_addr (slot_wide[ADDR_W-1:0]),
      .wr_data ({coord_z, coord_y, coord_x}),
      .rd_en   (cmd.issue_read),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign px = rd_data[COORD_BITS-1:0];
   assign py = rd_data[2*COORD_BITS-1:COORD_BITS];
   assign pz = rd_data[3*COORD_BITS-1:2*COORD_BITS];

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         qx_ff   <= coord_x;
         qy_ff   <= coord_y;
         qz_ff   <= coord_z;
         last_ff <= last_in;
         idx_ff  <= '0;
      end else if (cmd.issue_read) begin
         idx_ff  <= idx_in;
      end
   end

   always_comb begin
      sqx_in = SQ_W'(adx_ff) * SQ_W'(adx_ff);
      sqy_in = SQ_W'(ady_ff) * SQ_W'(ady_ff);
      sqz_in = SQ_W'(adz_ff) * SQ_W'(adz_ff);
      sum_c  = CMP_W'(sqx_ff) + CMP_W'(sqy_ff) + CMP_W'(sqz_ff);
      dist4_in = (sum_c > CMP_W'(DIST_MAX)) ? DIST_MAX : sum_c[DIST_W-1:0];
      better = v4_ff && (first_ff || (dist4_ff < best_dist_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue_read;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      i1_ff    <= idx_ff;
      i2_ff    <= i1_ff;
      adx_ff   <= abs_diff(qx_ff, px);
      ady_ff   <= abs_diff(qy_ff, py);
      adz_ff   <= abs_diff(qz_ff, pz);
      i3_ff    <= i2_ff;
      sqx_ff   <= sqx_in;
      sqy_ff   <= sqy_in;
      sqz_ff   <= sqz_in;
      i4_ff    <= i3_ff;
      dist4_ff <= dist4_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
      end else if (cmd.start_query) begin
         first_ff <= 1'b1;
      end else if (v4_ff) begin
         first_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_query) begin
         best_idx_ff  <= '0;
         best_dist_ff <= '0;
         empty_ff     <= status.count_zero;
      end else if (better) begin
         best_idx_ff  <= i4_ff;
         best_dist_ff <= dist4_ff;
      end
   end

   assign best_idx_wide = WIDE_W'(best_idx_ff);

   always_ff @(posedge clock) begin
      if (cmd.load_result) begin
         out_slot_ff  <= best_idx_wide[SLOT_W-1:0];
         out_dist_ff  <= best_dist_ff;
         out_empty_ff <= empty_ff;
      end
   end

   assign nearest_slot     = out_slot_ff;
   assign best_distance_sq = out_dist_ff;
   assign table_empty      = out_empty_ff;

endmodule

// ===== rtl/core/nearest_point_search_top.sv =====
// Brute-force 3-D nearest point search. A load transaction writes one point into the table
// and returns nothing; a query transaction scans table entries 0 to point_count-1
// (saturated to MAX_POINTS) through the single read port of the point memory, one entry
// per cycle, and returns the lowest index at the smallest squared distance. A query
// occupies the block for that one-entry-per-cycle scan plus the read, difference, square,
// sum and compare stages. With point_count zero the query skips the scan and the response
// carries index 0, distance 0 and table_empty set. A new transaction is taken while a
// finished response still waits on the output register.
module nearest_point_search_top #(
   parameter int MAX_POINTS = nps_pkg::DEFAULT_MAX_POINTS,
   parameter int COORD_BITS = nps_pkg::DEFAULT_COORD_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   nps_req_if.sink                     req_chan,
   nps_rsp_if.source                   rsp_chan,
   input  logic                        csr_write_enable,
   input  logic [nps_pkg::COUNT_W-1:0] csr_write_data
);
   import nps_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            req_ready;
   logic            rsp_valid;

   nps_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_operation (req_chan.operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_chan.ready),
      .status        (status),
      .cmd           (cmd)
   );

   nps_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .slot             (req_chan.slot),
      .coord_x          (req_chan.coord_x),
      .coord_y          (req_chan.coord_y),
      .coord_z          (req_chan.coord_z),
      .cmd              (cmd),
      .status           (status),
      .nearest_slot     (rsp_chan.nearest_slot),
      .best_distance_sq (rsp_chan.best_distance_sq),
      .table_empty      (rsp_chan.table_empty)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   // The scan pipeline must be empty whenever new work can be accepted.
   a_idle_pipe_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.pipe_busy)
      else $error("request accepted while scan pipeline busy");

   // A result is captured only after every distance has been compared.
   a_result_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |-> !status.pipe_busy)
      else $error("result captured before scan pipeline drained");

   a_result_presented: assert property (@(posedge clock) disable iff (reset)
      cmd.load_result |=> rsp_valid)
      else $error("captured result not presented");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_chan.table_empty) |->
         (rsp_chan.nearest_slot == '0 && rsp_chan.best_distance_sq == '0))
      else $error("empty table result carries nonzero payload");

endmodule

// ===== dv/nearest_point_search_top_tb.sv =====
`timescale 1ns / 100ps

module nearest_point_search_top_tb;
   import nps_pkg::*;

   localparam int MAX_POINTS  = DEFAULT_MAX_POINTS;
   localparam int COORD_BITS  = DEFAULT_COORD_BITS;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int MAX_REPORTS = 10;
   localparam int SETTLE_CYCLES = 32;
   localparam int INIT_POINTS = 48;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   typedef struct packed {
      logic              operation;
      logic [SLOT_W-1:0] slot;
      point_type         position;
   } request_type;

   typedef struct packed {
      logic [SLOT_W-1:0] nearest_slot;
      logic [DIST_W-1:0] best_distance_sq;
      logic              table_empty;
   } answer_type;

   localparam point_type HIGH_CORNER = '{COORD_MAX, COORD_MAX, COORD_MAX};
   localparam point_type LOW_CORNER  = '{COORD_MIN, COORD_MIN, COORD_MIN};
   localparam point_type ORIGIN      = '0;

   class nearest_point_tracker;
      point_type   points[MAX_POINTS];
      int unsigned point_count;
      answer_type  pending_answers[$];
      int unsigned loads;
      int unsigned queries;
      int unsigned empty_queries;
      int unsigned answers_checked;
      int unsigned failures;

      function void set_point_count(logic [COUNT_W-1:0] value);
         point_count = value;
      endfunction

      function logic [DIST_W-1:0] squared_distance(point_type a, point_type b);
         longint          dx;
         longint          dy;
         longint          dz;
         longint unsigned sum;
         dx = longint'($signed(a.x)) - longint'($signed(b.x));
         dy = longint'($signed(a.y)) - longint'($signed(b.y));
         dz = longint'($signed(a.z)) - longint'($signed(b.z));
         sum = dx * dx + dy * dy + dz * dz;
         if (sum > DIST_MAX) begin
            sum = DIST_MAX;
         end
         return sum[DIST_W-1:0];
      endfunction

      function void note_request(request_type r);
         answer_type        a;
         int unsigned       n;
         int unsigned       i;
         logic [DIST_W-1:0] d;
         if (r.operation == OP_LOAD) begin
            points[r.slot] = r.position;
            loads++;
            return;
         end
         queries++;
         n = (point_count > MAX_POINTS) ? MAX_POINTS : point_count;
         a = '0;
         if (n == 0) begin
            a.table_empty = 1'b1;
            empty_queries++;
         end else begin
            a.best_distance_sq = squared_distance(r.position, points[0]);
            for (i = 1; i < n; i++) begin
               d = squared_distance(r.position, points[i]);
               if (d < a.best_distance_sq) begin
                  a.best_distance_sq = d;
                  a.nearest_slot = SLOT_W'(i);
               end
            end
         end
         pending_answers = {pending_answers, a};
      endfunction

      function void check_answer(answer_type got);
         answer_type want;
         if (pending_answers.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("ERROR: unexpected response slot=%0d dist=%0d empty=%0b",
                        got.nearest_slot, got.best_distance_sq, got.table_empty);
            end
            return;
         end
         want = pending_answers.pop_front();
         answers_checked++;
         if (got.nearest_slot !== want.nearest_slot ||
             got.best_distance_sq !== want.best_distance_sq ||
             got.table_empty !== want.table_empty) begin
            failures++;
            if (failures <= MAX_REPORTS) begin
               $display("ERROR: response %0d expected slot=%0d dist=%0d empty=%0b",
                        answers_checked, want.nearest_slot, want.best_distance_sq,
                        want.table_empty);
               $display("       got slot=%0d dist=%0d empty=%0b",
                        got.nearest_slot, got.best_distance_sq, got.table_empty);
            end
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic [COUNT_W-1:0] csr_write_data;

   int unsigned send_gap_pct    = 0;
   int unsigned stall_pct       = 0;
   int unsigned hold_off_cycles = 0;
   int unsigned settings_used   = 0;

   nearest_point_tracker tracker = new();

   nps_req_if #(.COORD_BITS(COORD_BITS)) req_bus ();
   nps_rsp_if rsp_bus ();

   nearest_point_search_top #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_bus),
      .rsp_chan         (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic point_type random_point();
      point_type p;
      p.x = coord_type'($urandom());
      p.y = coord_type'($urandom());
      p.z = coord_type'($urandom());
      return p;
   endfunction

   function automatic coord_type jitter(coord_type c);
      return c + coord_type'($urandom_range(0, 64)) - coord_type'(32);
   endfunction

   function automatic point_type near_point(int unsigned n);
      point_type p;
      p = tracker.points[$urandom_range(0, n - 1)];
      p.x = jitter(p.x);
      p.y = jitter(p.y);
      p.z = jitter(p.z);
      return p;
   endfunction

   function automatic request_type make_load(int unsigned slot, point_type p);
      request_type r;
      r.operation = OP_LOAD;
      r.slot      = SLOT_W'(slot);
      r.position  = p;
      return r;
   endfunction

   function automatic request_type make_query(point_type p);
      request_type r;
      r.operation = OP_QUERY;
      r.slot      = SLOT_W'($urandom());
      r.position  = p;
      return r;
   endfunction

   task automatic send_request(input request_type r);
      if (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= r.operation;
      req_bus.slot      <= r.slot;
      req_bus.coord_x   <= r.position.x;
      req_bus.coord_y   <= r.position.y;
      req_bus.coord_z   <= r.position.z;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_request(r);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (tracker.pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_point_count(input logic [COUNT_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_point_count(value);
      settings_used++;
   endtask

   task automatic run_random_phase(input int unsigned count, input int unsigned items,
                                   input bit idle);
      request_type r;
      point_type   p;
      int unsigned n;
      write_point_count(COUNT_W'(count));
      send_gap_pct = idle ? 10 * $urandom_range(0, 3) : 0;
      stall_pct    = idle ? 5 * $urandom_range(0, 3) : 0;
      n = (count > MAX_POINTS) ? MAX_POINTS : count;
      repeat (items) begin
         if ($urandom_range(0, 1) == 1) begin
            if (n != 0 && $urandom_range(0, 4) < 3) begin
               p = near_point(n);
            end else begin
               p = random_point();
            end
            r = make_query(p);
         end else begin
            if (n != 0 && $urandom_range(0, 1) == 1) begin
               p = tracker.points[$urandom_range(0, n - 1)];
            end else begin
               p = random_point();
            end
            if (n != 0 && $urandom_range(0, 9) < 7) begin
               r = make_load($urandom_range(0, n - 1), p);
            end else begin
               r = make_load($urandom(), p);
            end
         end
         send_request(r);
      end
   endtask

   initial begin
      int unsigned stall;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            tracker.check_answer('{rsp_bus.nearest_slot, rsp_bus.best_distance_sq,
                                   rsp_bus.table_empty});
         end
         if (hold_off_cycles > 0) begin
            stall = hold_off_cycles;
            hold_off_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned elapsed_cycles;
      elapsed_cycles = 0;
      while (elapsed_cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         elapsed_cycles++;
      end
      $display("ERROR: timeout after %0d cycles, %0d responses outstanding",
               elapsed_cycles, tracker.pending_answers.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      int unsigned i;
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_write_data    <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.operation <= OP_LOAD;
      req_bus.slot      <= '0;
      req_bus.coord_x   <= '0;
      req_bus.coord_y   <= '0;
      req_bus.coord_z   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With point_count still at its reset value the table counts as empty.
      send_request(make_query(HIGH_CORNER));
      send_request(make_query(LOW_CORNER));

      // The low entries are written once so that no later query reaches an unwritten one.
      for (i = 0; i < INIT_POINTS; i++) begin
         send_request(make_load(i, random_point()));
      end

      write_point_count(1);
      send_request(make_load(0, LOW_CORNER));
      send_request(make_query(HIGH_CORNER));
      send_request(make_query(LOW_CORNER));

      write_point_count(4);
      send_request(make_load(0, HIGH_CORNER));
      send_request(make_load(1, LOW_CORNER));
      send_request(make_load(2, ORIGIN));
      send_request(make_load(3, ORIGIN));
      send_request(make_query(HIGH_CORNER));
      send_request(make_query(LOW_CORNER));
      send_request(make_query(ORIGIN));
      send_request(make_query('{coord_type'(1), coord_type'(1), coord_type'(1)}));
      send_request(make_query('{COORD_MAX, COORD_MIN, coord_type'(0)}));

      write_point_count(0);
      send_request(make_query(random_point()));

      run_random_phase(3, 8, 1'b1);
      run_random_phase(17, 8, 1'b1);
      run_random_phase(1, 6, 1'b1);
      run_random_phase($urandom_range(24, INIT_POINTS), 8, 1'b1);
      run_random_phase(2, 6, 1'b1);
      run_random_phase(INIT_POINTS, 8, 1'b1);
      run_random_phase($urandom_range(5, 40), 8, 1'b1);

      // The response side holds off while queries keep coming, so the input stalls.
      write_point_count(5);
      send_gap_pct = 0;
      stall_pct    = 0;
      hold_off_cycles = 300;
      repeat (12) send_request(make_query(near_point(5)));

      run_random_phase(12, 14, 1'b0);

      settle();
      $display("Run covered %0d loads and %0d queries (%0d on an empty table) over %0d counts.",
               tracker.loads, tracker.queries, tracker.empty_queries, settings_used);
      $display("Responses checked: %0d, mismatches: %0d.",
               tracker.answers_checked, tracker.failures);
      if (tracker.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/nps_pkg.sv
rtl/core/nps_req_if.sv
rtl/core/nps_rsp_if.sv
rtl/core/nps_ram.sv
rtl/core/nps_ctrl.sv
rtl/core/nps_datapath.sv
rtl/core/nearest_point_search_top.sv
dv/nearest_point_search_top_tb.sv
